@@ rtl/core/pdcm_pkg.sv @@
// shared constants and types for the pwm duty-cycle meter
package pdcm_pkg;

	localparam int IVL_W          = 16;
	localparam int SCALE_W        = 10;
	localparam int DUTY_W         = 17;
	localparam int PCT_W          = 7;
	localparam int S_TDATA_W      = 16;
	localparam int M_TDATA_W      = 24;
	localparam int RING_DEPTH_DEF = 8;

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(10);
	localparam logic [PCT_W-1:0]   PERCENT   = PCT_W'(100);

	// quotient bits produced by the divider
	localparam int QUO_W = DUTY_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic cap;
		logic upd;
		logic mul1;
		logic mul2;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

@@ rtl/core/pdcm_ctrl.sv @@
// sequencing state machine and output valid flag
module pdcm_ctrl
	import pdcm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_vld_q || m_tready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

endmodule

@@ rtl/core/pdcm_dp.sv @@
// rings, running totals, multiplier, restoring divider and output register
module pdcm_dp
	import pdcm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 pin_high,
	input  logic [IVL_W-1:0]     interval,
	input  logic                 cfg_we,
	input  logic [SCALE_W-1:0]   cfg_scale,
	output logic [DUTY_W-1:0]    duty,
	output logic                 no_period
);

	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int TOT_W  = IVL_W + $clog2(RING_DEPTH);
	localparam int PER_W  = TOT_W + 1;
	localparam int PRD_W  = TOT_W + SCALE_W;
	localparam int NUM_W  = PRD_W + PCT_W;
	localparam int CNT_W  = $clog2(QUO_W);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(QUO_W - 1);

	logic [IVL_W-1:0]      low_mem  [RING_DEPTH];
	logic [IVL_W-1:0]      high_mem [RING_DEPTH];
	logic                  low_wrap_q, high_wrap_q;
	logic [SLOT_W-1:0]     low_slot_q, high_slot_q;
	logic [TOT_W-1:0]      low_total_q, high_total_q;
	logic [IVL_W-1:0]      low_rd_q, high_rd_q;
	logic                  low_rd_vld_q, high_rd_vld_q;
	logic                  pin_q;
	logic [IVL_W-1:0]      ivl_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [PRD_W-1:0]      prod_q;
	logic [PER_W-1:0]      per_q;
	logic [PER_W-1:0]      rem_q;
	logic [QUO_W-1:0]      nlo_q;
	logic [QUO_W-1:0]      quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DUTY_W-1:0]     duty_q;
	logic                  nop_q;

	logic [IVL_W-1:0]      low_old, high_old;
	logic [NUM_W-1:0]      num;
	logic [PER_W:0]        rem_n;
	logic [PER_W:0]        rem_sub;
	logic                  q_bit;

	// ring storage, read at the capture beat, written during the update step
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			low_rd_q  <= low_mem[low_slot_q];
			high_rd_q <= high_mem[high_slot_q];
		end
		if (cmd.upd && pin_q) begin
			low_mem[low_slot_q] <= ivl_q;
		end
		if (cmd.upd && !pin_q) begin
			high_mem[high_slot_q] <= ivl_q;
		end
	end

	assign low_old  = low_rd_vld_q  ? low_rd_q  : '0;
	assign high_old = high_rd_vld_q ? high_rd_q : '0;

	// slots fill in order, so every entry holds data once a ring has wrapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_wrap_q    <= 1'b0;
			high_wrap_q   <= 1'b0;
			low_slot_q    <= '0;
			high_slot_q   <= '0;
			low_total_q   <= '0;
			high_total_q  <= '0;
			low_rd_vld_q  <= 1'b0;
			high_rd_vld_q <= 1'b0;
			scale_q       <= SCALE_RST;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_scale;
			end
			if (cmd.cap) begin
				low_rd_vld_q  <= low_wrap_q;
				high_rd_vld_q <= high_wrap_q;
			end
			if (cmd.upd) begin
				if (pin_q) begin
					if (low_slot_q == SLOT_LAST) begin
						low_wrap_q <= 1'b1;
					end
					low_total_q <= low_total_q - TOT_W'(low_old) + TOT_W'(ivl_q);
					low_slot_q  <= (low_slot_q == SLOT_LAST) ? '0 : low_slot_q + 1'b1;
				end else begin
					if (high_slot_q == SLOT_LAST) begin
						high_wrap_q <= 1'b1;
					end
					high_total_q <= high_total_q - TOT_W'(high_old) + TOT_W'(ivl_q);
					high_slot_q  <= (high_slot_q == SLOT_LAST) ? '0 : high_slot_q + 1'b1;
				end
			end
		end
	end

	// numerator high_total * scale * 100 over two multiply steps
	assign num = NUM_W'(prod_q) * NUM_W'(PERCENT);

	// one restoring division step per cycle, quotient known to fit QUO_W bits
	assign rem_n   = {rem_q, nlo_q[QUO_W-1]};
	assign rem_sub = rem_n - {1'b0, per_q};
	assign q_bit   = (rem_n >= {1'b0, per_q});

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pin_q <= pin_high;
			ivl_q <= interval;
		end
		if (cmd.mul1) begin
			prod_q <= PRD_W'(high_total_q) * PRD_W'(scale_q);
			per_q  <= PER_W'(low_total_q) + PER_W'(high_total_q);
		end
		if (cmd.mul2) begin
			rem_q <= PER_W'(num[NUM_W-1:QUO_W]);
			nlo_q <= num[QUO_W-1:0];
			cnt_q <= CNT_LAST;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sub[PER_W-1:0] : rem_n[PER_W-1:0];
			nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.load) begin
			nop_q  <= (per_q == '0);
			duty_q <= (per_q == '0) ? '0 : quo_q;
		end
	end

	assign sts.div_last = (cnt_q == '0);
	assign duty         = duty_q;
	assign no_period    = nop_q;

endmodule

@@ rtl/core/pwm_duty_cycle_meter_top.sv @@
// Duty-cycle meter top level. Each input beat is one captured pwm edge: tuser carries the
// pin level after the edge (1 rising, interval was low time; 0 falling, interval was high
// time) and tdata the 16-bit timer count since the previous edge. The interval enters an
// eight-deep (RING_DEPTH) ring for its phase, replacing the oldest entry, and one result
// beat follows per edge: duty = high_sum * 100 * scale / (high_sum + low_sum), truncated,
// with tuser set and duty 0 when both sums are zero. An edge passes the update step, two
// multiply steps and the bit-serial divider before its result can be loaded into the output
// register; a new edge is accepted in the cycle after the result is loaded, even while that
// result still waits to be taken. scale resets to 10 and is written on the cfg channel.
module pwm_duty_cycle_meter_top
	import pdcm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // interval[15:0]
	input  logic                 s_tuser,   // pin_high
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // duty[16:0], zero fill above
	output logic                 m_tuser,   // no_period
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SCALE_W-1:0]   cfg_data   // scale
);

	cmd_t              cmd;
	sts_t              sts;
	logic [DUTY_W-1:0] duty;

	assign cfg_ready = 1'b1;

	pdcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdcm_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pin_high  (s_tuser),
		.interval  (s_tdata[IVL_W-1:0]),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_scale (cfg_data),
		.duty      (duty),
		.no_period (m_tuser)
	);

	assign m_tdata = M_TDATA_W'(duty);

endmodule

@@ rtl/core/pdcm_chk.sv @@
// port-level checker for the duty-cycle meter and its bind
module pdcm_chk
	import pdcm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// no period means zero duty
	a_nop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("duty not zero with no period");

	// duty never above 100 times the largest scale
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= M_TDATA_W'(102300))
		else $error("duty out of range");

	// one edge at a time: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

endmodule

bind pwm_duty_cycle_meter_top pdcm_chk u_pdcm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
